// ----- hw/rtl/tiered_period_scheduler_defines.svh -----
// Assertion macros for the tiered period scheduler.
`ifndef TIERED_PERIOD_SCHEDULER_DEFINES_SVH
`define TIERED_PERIOD_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define TPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPS_ASSERT(label, clk, rst, prop, msg)
`define TPS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/tps_pkg.sv -----
`default_nettype none
package tps_pkg;
  localparam logic [2:0] KIND_TICK = 3'd0;
  localparam logic [2:0] KIND_ADD = 3'd1;
  localparam logic [2:0] KIND_RETIER = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;
  localparam logic [2:0] KIND_QUERY = 3'd5;
  localparam logic [2:0] KIND_MARK = 3'd6;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_TIER = 2'd1;
  localparam logic [1:0] ERR_KEY = 2'd2;

  localparam int RESULT_CAP = 32;

  // Operation a cell applies when the edit token reaches it.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_PLACE = 3'd1;
  localparam logic [2:0] OP_DROP = 3'd2;
  localparam logic [2:0] OP_STAMP = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_SCAN = 3'd5;
  localparam logic [2:0] OP_PEEK = 3'd6;

  typedef struct packed {
    logic       live;
    logic [2:0] op;
    logic [5:0] key;
    logic [2:0] tier;
    logic       cap;
  } tok_t;
endpackage
`default_nettype wire

// ----- hw/rtl/tps_cell.sv -----
`default_nettype none
module tps_cell #(
  parameter int INDEX = 0,
  parameter int NUM_TIERS = 4,
  parameter int TICK_BITS = 32,
  parameter int TW = 2
) (
  input  wire                   clk,
  input  wire                   rst,
  input  tps_pkg::tok_t         tok,
  input  wire  [TICK_BITS-1:0]  tick_count,
  input  wire  [TICK_BITS-1:0]  period,
  output logic [TW-1:0]         tier,
  output logic                  present,
  output logic [TICK_BITS-1:0]  since,
  output logic                  due
);
  logic [TICK_BITS-1:0] stamp;
  logic                 hit;

  assign hit = tok.live && (tok.key == 6'(INDEX));
  assign since = tick_count - stamp;
  assign due = present && (tier != TW'(NUM_TIERS - 1)) && (since >= period);

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      tier <= '0;
      stamp <= '0;
    end else if (tok.live && tok.op == tps_pkg::OP_CLEAR) begin
      present <= 1'b0;
      tier <= '0;
      stamp <= '0;
    end else if (hit) begin
      case (tok.op)
        tps_pkg::OP_PLACE: begin
          present <= 1'b1;
          tier <= TW'(tok.tier);
          stamp <= tick_count;
        end
        tps_pkg::OP_DROP: begin
          present <= 1'b0;
          tier <= '0;
          stamp <= '0;
        end
        tps_pkg::OP_STAMP: stamp <= tick_count;
        tps_pkg::OP_SCAN: if (due && !tok.cap) stamp <= tick_count;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tiered_period_scheduler.sv -----
// An edit or query result passes through the token register, the pending result register and
// then the output register; the next beat is taken once the result has left the pending register.
// A tick visits every slot in key order, sending a scan token to each slot in turn; an empty tick
// still answers with one result marked last, and input is taken again once the walk is over.
// A stalled result receiver holds the walk and delays these results and the next beat.
// Reset (synchronous) empties the table, zeroes the tick counter and sets every period to 1.
`default_nettype none
`include "tiered_period_scheduler_defines.svh"
module tiered_period_scheduler #(
  parameter int MAX_ENTRIES = 32,
  parameter int NUM_TIERS = 4,
  parameter int TICK_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  kind,
  input  wire  [4:0]  key,
  input  wire  [2:0]  tier_in,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [4:0]  out_key,
  output logic [1:0]  out_tier,
  output logic [31:0] elapsed,
  output logic        found,
  output logic        due_valid,
  output logic [1:0]  error,
  output logic        last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  localparam int TW = $clog2(NUM_TIERS);
  localparam int KW = $clog2(MAX_ENTRIES);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EDIT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  logic [1:0]           state;
  logic [TICK_BITS-1:0] tick_count;
  logic [TICK_BITS-1:0] period [NUM_TIERS-1];
  tps_pkg::tok_t        tok;
  logic [KW:0]          scan_key;
  logic [5:0]           n_due;
  logic                 pend_valid;
  logic [4:0]           pend_key;
  logic [1:0]           pend_tier;
  logic [31:0]          pend_elapsed;
  logic                 pend_found;
  logic [1:0]           pend_err;
  logic                 pend_due;
  logic                 pend_last;
  logic [2:0]           op_kind;
  logic [4:0]           op_key;

  logic [TW-1:0]        c_tier [MAX_ENTRIES];
  logic                 c_present [MAX_ENTRIES];
  logic [TICK_BITS-1:0] c_since [MAX_ENTRIES];
  logic                 c_due [MAX_ENTRIES];
  logic [TICK_BITS-1:0] c_period [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] due_vec;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      assign c_period[g] = (c_tier[g] == TW'(NUM_TIERS - 1)) ? '0 : period[c_tier[g]];
      assign due_vec[g] = c_due[g];
      tps_cell #(.INDEX(g), .NUM_TIERS(NUM_TIERS), .TICK_BITS(TICK_BITS), .TW(TW)) u_cell (
        .clk(clk), .rst(rst), .tok(tok), .tick_count(tick_count),
        .period(c_period[g]), .tier(c_tier[g]), .present(c_present[g]),
        .since(c_since[g]), .due(c_due[g])
      );
    end
  endgenerate

  // Slot the token names this cycle, read for the tick walk and queries.
  logic [KW-1:0]        sel;
  logic                 sel_ok;
  logic                 sel_present;
  logic [TW-1:0]        sel_tier;
  logic [TICK_BITS-1:0] sel_since;
  logic                 sel_due;
  logic [MAX_ENTRIES-1:0] due_above;
  assign sel = KW'(tok.key);
  assign sel_ok = (32'(tok.key) < 32'(MAX_ENTRIES));
  assign sel_present = sel_ok && c_present[sel];
  assign sel_tier = c_tier[sel];
  assign sel_since = c_since[sel];
  assign sel_due = sel_ok && c_due[sel];
  // Slots above the current one keep their state until the walk reaches them.
  assign due_above = (due_vec >> sel) >> 1;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && !pend_valid;
  assign cfg_ready = 1'b1;

  logic key_ok, key_present, tier_ok;
  logic [KW-1:0] key_sel;
  assign key_sel = KW'(key);
  assign key_ok = (32'(key) < 32'(MAX_ENTRIES));
  assign key_present = key_ok && c_present[key_sel];
  assign tier_ok = (32'(tier_in) < 32'(NUM_TIERS));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIERS - 1; i++) period[i] <= TICK_BITS'(1);
    end else if (cfg_valid && cfg_index < 2'(NUM_TIERS - 1) && cfg_index != 2'd3) begin
      period[cfg_index] <= TICK_BITS'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tick_count <= '0;
      tok <= '0;
      scan_key <= '0;
      n_due <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (pend_valid && out_free) begin
        out_valid <= 1'b1;
        out_key <= pend_key;
        out_tier <= pend_tier;
        elapsed <= pend_elapsed;
        found <= pend_found;
        error <= pend_err;
        due_valid <= pend_due;
        last <= pend_last;
        pend_valid <= 1'b0;
      end
      tok.live <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            op_kind <= kind;
            op_key <= key;
            if (kind == tps_pkg::KIND_TICK) begin
              tick_count <= tick_count + TICK_BITS'(1);
              n_due <= '0;
              scan_key <= '0;
              state <= ST_SCAN;
            end else begin
              tok.live <= 1'b1;
              tok.key <= 6'(key);
              tok.tier <= tier_in;
              tok.cap <= 1'b0;
              tok.op <= tps_pkg::OP_PEEK;
              pend_err <= tps_pkg::ERR_OK;
              case (kind)
                tps_pkg::KIND_ADD:
                  if (!key_ok) pend_err <= tps_pkg::ERR_KEY;
                  else if (!tier_ok) pend_err <= tps_pkg::ERR_TIER;
                  else tok.op <= tps_pkg::OP_PLACE;
                tps_pkg::KIND_RETIER:
                  if (!key_present) pend_err <= tps_pkg::ERR_KEY;
                  else if (!tier_ok) pend_err <= tps_pkg::ERR_TIER;
                  else if (c_tier[key_sel] != TW'(tier_in))
                    tok.op <= tps_pkg::OP_PLACE;
                tps_pkg::KIND_REMOVE:
                  if (key_present) tok.op <= tps_pkg::OP_DROP;
                  else if (!key_ok) pend_err <= tps_pkg::ERR_KEY;
                tps_pkg::KIND_CLEAR: tok.op <= tps_pkg::OP_CLEAR;
                tps_pkg::KIND_QUERY:
                  if (!key_present) pend_err <= tps_pkg::ERR_KEY;
                tps_pkg::KIND_MARK:
                  if (!key_present) pend_err <= tps_pkg::ERR_KEY;
                  else if (c_tier[key_sel] != TW'(NUM_TIERS - 1))
                    tok.op <= tps_pkg::OP_STAMP;
                default: ;
              endcase
              state <= ST_EDIT;
            end
          end
        end
        ST_EDIT: begin
          pend_valid <= 1'b1;
          pend_key <= op_key;
          pend_due <= 1'b0;
          pend_tier <= '0;
          pend_elapsed <= '0;
          pend_found <= 1'b0;
          pend_last <= 1'b1;
          if (op_kind == tps_pkg::KIND_QUERY && sel_present) begin
            pend_tier <= 2'(sel_tier);
            pend_elapsed <= 32'(sel_since);
            pend_found <= 1'b1;
          end
          state <= ST_WAIT;
        end
        ST_SCAN: begin
          if (!pend_valid || out_free) begin
            if (!tok.live) begin
              if (32'(scan_key) < 32'(MAX_ENTRIES)) begin
                tok.live <= 1'b1;
                tok.op <= tps_pkg::OP_SCAN;
                tok.key <= 6'(scan_key);
                tok.cap <= (n_due == 6'(tps_pkg::RESULT_CAP));
                scan_key <= scan_key + (KW + 1)'(1);
              end else begin
                if (n_due == '0) begin
                  pend_valid <= 1'b1;
                  pend_key <= '0;
                  pend_tier <= '0;
                  pend_elapsed <= '0;
                  pend_found <= 1'b0;
                  pend_err <= tps_pkg::ERR_OK;
                  pend_due <= 1'b0;
                  pend_last <= 1'b1;
                end
                state <= ST_WAIT;
              end
            end else if (sel_due && !tok.cap) begin
              pend_valid <= 1'b1;
              pend_key <= 5'(tok.key);
              pend_tier <= 2'(sel_tier);
              pend_elapsed <= 32'(sel_since);
              pend_found <= 1'b0;
              pend_err <= tps_pkg::ERR_OK;
              pend_due <= 1'b1;
              pend_last <= !(|due_above) || (n_due == 6'(tps_pkg::RESULT_CAP - 1));
              n_due <= n_due + 6'd1;
            end
          end else begin
            tok.live <= tok.live;
          end
        end
        ST_WAIT: begin
          if (!pend_valid) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TPS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `TPS_ASSERT(a_busy_no_accept, clk, rst, state != ST_IDLE |-> !in_ready, "accept while busy")
  `TPS_ASSERT(a_cap, clk, rst, n_due <= 6'(tps_pkg::RESULT_CAP), "too many due results")
endmodule
`default_nettype wire
